>>> src/egcd_pkg.sv
// ----------------------------------------------------------------------------
// egcd_pkg
// shared widths, command and status types for the extended gcd core
// ----------------------------------------------------------------------------
package egcd_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int MAG_W       = DATA_WIDTH - 1;
    localparam int CNT_W       = $clog2(MAG_W);
    localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((MAG_W + 2 * DATA_WIDTH + 7) / 8) * 8;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic update;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic r1_zero;
        logic out_busy;
    } dp_status_t;

    // magnitude of a two's complement operand, most negative value saturated
    function automatic logic [MAG_W-1:0] magnitude(input logic [DATA_WIDTH-1:0] v);
        logic [DATA_WIDTH-1:0] neg_v;
        logic [MAG_W-1:0]      res;
        neg_v = -v;
        if (!v[DATA_WIDTH-1]) begin
            res = v[MAG_W-1:0];
        end else if (v[MAG_W-1:0] == '0) begin
            res = '1;
        end else begin
            res = neg_v[MAG_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> src/egcd_ctrl.sv
// ----------------------------------------------------------------------------
// egcd_ctrl
// sequencer for the euclid rounds and the bit-serial division steps
// ----------------------------------------------------------------------------
module egcd_ctrl
    import egcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_DIVIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = status.r1_zero ? ST_FINISH : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAG_W - 1)) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINISH: begin
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> src/egcd_datapath.sv
// ----------------------------------------------------------------------------
// egcd_datapath
// remainder pair, restoring divider and coefficient accumulators
// ----------------------------------------------------------------------------
module egcd_datapath
    import egcd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  dp_cmd_t                cmd,
    output dp_status_t             status
);

    logic [DATA_WIDTH-1:0] in_a, in_b;
    logic [MAG_W-1:0]      r0_reg, r1_reg, rem_reg, dvd_reg;
    logic [DATA_WIDTH-1:0] s0_reg, s1_reg, t0_reg, t1_reg, acc_s_reg, acc_t_reg;
    logic                  neg_a_reg, neg_b_reg, zero_a_reg, zero_b_reg;
    logic [MAG_W-1:0]      gcd_reg;
    logic [DATA_WIDTH-1:0] x_reg, y_reg;
    logic                  out_valid_reg;

    logic [MAG_W:0]        rem_ext, diff;
    logic                  ge;
    logic [MAG_W-1:0]      rem_next;
    logic [DATA_WIDTH-1:0] acc_s_next, acc_t_next, x_next, y_next;

    assign in_a = s_tdata[DATA_WIDTH-1:0];
    assign in_b = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

    // one quotient bit per cycle, msb first
    assign rem_ext    = {rem_reg, dvd_reg[MAG_W-1]};
    assign diff       = rem_ext - {1'b0, r1_reg};
    assign ge         = !diff[MAG_W];
    assign rem_next   = ge ? diff[MAG_W-1:0] : rem_ext[MAG_W-1:0];
    assign acc_s_next = {acc_s_reg[DATA_WIDTH-2:0], 1'b0} + (ge ? s1_reg : '0);
    assign acc_t_next = {acc_t_reg[DATA_WIDTH-2:0], 1'b0} + (ge ? t1_reg : '0);

    // fold operand signs into the coefficients
    assign x_next = zero_a_reg ? '0 : (neg_a_reg ? -s0_reg : s0_reg);
    assign y_next = zero_b_reg ? '0 : (neg_b_reg ? -t0_reg : t0_reg);

    assign status.r1_zero  = (r1_reg == '0);
    assign status.out_busy = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({y_reg, x_reg, gcd_reg});

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            r0_reg     <= magnitude(in_a);
            r1_reg     <= magnitude(in_b);
            s0_reg     <= DATA_WIDTH'(1);
            s1_reg     <= '0;
            t0_reg     <= '0;
            t1_reg     <= DATA_WIDTH'(1);
            neg_a_reg  <= in_a[DATA_WIDTH-1];
            neg_b_reg  <= in_b[DATA_WIDTH-1];
            zero_a_reg <= (in_a == '0);
            zero_b_reg <= (in_b == '0);
        end
        if (cmd.div_init) begin
            rem_reg   <= '0;
            dvd_reg   <= r0_reg;
            acc_s_reg <= '0;
            acc_t_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg   <= rem_next;
            dvd_reg   <= {dvd_reg[MAG_W-2:0], 1'b0};
            acc_s_reg <= acc_s_next;
            acc_t_reg <= acc_t_next;
        end
        if (cmd.update) begin
            r0_reg <= r1_reg;
            r1_reg <= rem_reg;
            s0_reg <= s1_reg;
            s1_reg <= s0_reg - acc_s_reg;
            t0_reg <= t1_reg;
            t1_reg <= t0_reg - acc_t_reg;
        end
        if (cmd.finish) begin
            gcd_reg <= r0_reg;
            x_reg   <= x_next;
            y_reg   <= y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |=> rem_reg < r1_reg)
        else $error("partial remainder not below divisor");

    a_remainders_descend: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> r1_reg < r0_reg)
        else $error("remainder pair not descending after round");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !(out_valid_reg && !m_tready))
        else $error("result overwritten before transaction");

    a_finish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> out_valid_reg)
        else $error("result not presented after finish");

endmodule

>>> src/extended_gcd_bezout_core.sv
// ----------------------------------------------------------------------------
// extended_gcd_bezout_core
// extended euclid core: gcd of two signed operands with bezout coefficients
// ----------------------------------------------------------------------------
// One operand pair in, one result out: gcd(|a|,|b|) with x, y such that
// x*a + y*b = gcd; a most negative operand is saturated by one. Operands are
// handled one at a time. Each euclid round runs a radix-2 restoring divider,
// producing one quotient bit per cycle, between a check and an update state;
// for 32-bit operands an item takes at most 45 rounds. The finish state also
// waits while a previous result still sits on the output unaccepted. The
// next pair is taken while a finished result still waits on the output.
module extended_gcd_bezout_core
    import egcd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // first_value, second_value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // divisor_result, coeff_first, coeff_second
);

    dp_cmd_t    cmd;
    dp_status_t status;

    egcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    egcd_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench for the extended gcd core with bezout coefficients
// ----------------------------------------------------------------------------
// Operand pairs go in over the slave stream, and each result transaction is
// checked field by field against an in-bench model of the extended euclid
// recurrence on saturated magnitudes, with the input signs folded into x and y.
// The run covers zero operands, the most negative and largest values, long
// fibonacci chains and random pairs. The random pairs are sent under four mixes
// of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_top;
    import egcd_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 1600;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int PRINT_LIMIT  = 50;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        logic [MAG_W-1:0] gcd;
        word_t            coeff_a;
        word_t            coeff_b;
    } bezout_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // first_value, second_value
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // divisor_result, coeff_first, coeff_second

    bezout_t pending_bezout[$];
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      sent_count     = 0;
    int      checked_count  = 0;
    int      err_count      = 0;
    int      cycle_count    = 0;

    extended_gcd_bezout_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("end of test: mismatches");
        $finish;
    end

    // saturated magnitude, euclid loop modulo 2^DATA_WIDTH, signs folded in
    function automatic bezout_t compute_bezout(input word_t a, input word_t b);
        word_t   top;
        word_t   r0, r1, s0, s1, t0, t1, q, rn, sn, tn;
        bezout_t res;
        top = word_t'(1) << (DATA_WIDTH - 1);
        r0  = (a == top) ? top - 1 : (a[DATA_WIDTH-1] ? -a : a);
        r1  = (b == top) ? top - 1 : (b[DATA_WIDTH-1] ? -b : b);
        s0  = 1;
        s1  = 0;
        t0  = 0;
        t1  = 1;
        while (r1 != 0) begin
            q  = r0 / r1;
            rn = r0 - q * r1;
            sn = s0 - q * s1;
            tn = t0 - q * t1;
            r0 = r1;
            r1 = rn;
            s0 = s1;
            s1 = sn;
            t0 = t1;
            t1 = tn;
        end
        res.gcd     = r0[MAG_W-1:0];
        res.coeff_a = (a == 0) ? word_t'(0) : (a[DATA_WIDTH-1] ? -s0 : s0);
        res.coeff_b = (b == 0) ? word_t'(0) : (b[DATA_WIDTH-1] ? -t0 : t0);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_count < PRINT_LIMIT) begin
            $display("mismatch at result %0d, %s: got %h, expected %h",
                     checked_count, what, got, want);
        end
        err_count++;
    endtask

    task automatic send_pair(input word_t a, input word_t b);
        bezout_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({b, a});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = compute_bezout(a, b);
        pending_bezout = {pending_bezout, want};
        sent_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        bezout_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bezout.size() == 0) begin
                report_mismatch("unexpected transaction", 64'(m_tdata), 64'(0));
            end else begin
                want = pending_bezout.pop_front();
                if (m_tdata[MAG_W-1:0] !== want.gcd)
                    report_mismatch("divisor_result", 64'(m_tdata[MAG_W-1:0]),
                                    64'(want.gcd));
                if (m_tdata[MAG_W +: DATA_WIDTH] !== want.coeff_a)
                    report_mismatch("coeff_first", 64'(m_tdata[MAG_W +: DATA_WIDTH]),
                                    64'(want.coeff_a));
                if (m_tdata[MAG_W+DATA_WIDTH +: DATA_WIDTH] !== want.coeff_b)
                    report_mismatch("coeff_second",
                                    64'(m_tdata[MAG_W+DATA_WIDTH +: DATA_WIDTH]),
                                    64'(want.coeff_b));
            end
            checked_count++;
        end
    end

    function automatic word_t random_sign(input word_t v);
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic word_t random_operand();
        word_t top;
        word_t v;
        top = word_t'(1) << (DATA_WIDTH - 1);
        case ($urandom_range(9))
            0, 1, 2, 3: v = word_t'($urandom());
            4, 5:       v = random_sign(word_t'($urandom_range(1000)));
            6:          v = random_sign(word_t'($urandom_range(65535)));
            7:          v = random_sign(word_t'($urandom_range(1 << 24)));
            default: begin
                case ($urandom_range(4))
                    0:       v = 0;
                    1:       v = top;
                    2:       v = top - 1;
                    3:       v = top + 1;
                    default: v = random_sign(word_t'(1));
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic test_zero_operands();
        word_t top;
        top = word_t'(1) << (DATA_WIDTH - 1);
        send_pair(0, 0);
        send_pair(5, 0);
        send_pair(-5, 0);
        send_pair(0, 7);
        send_pair(0, -7);
        send_pair(top - 1, 0);
        send_pair(top, 0);
        send_pair(0, top);
    endtask

    task automatic test_extremes();
        word_t top;
        top = word_t'(1) << (DATA_WIDTH - 1);
        send_pair(top, top);
        send_pair(top - 1, top - 1);
        send_pair(top - 1, top);
        send_pair(top, 1);
        send_pair(1, top);
        send_pair(-1, -1);
        send_pair(1, -1);
        send_pair(top - 1, top - 2);
        send_pair(32'haaaaaaaa, 32'h55555555);
        send_pair(3, 1000);
        send_pair(12, 18);
        send_pair(-12, 18);
        send_pair(12, -18);
        send_pair(-240, -46);
        send_pair(6, 6);
    endtask

    // consecutive fibonacci numbers force the longest quotient chains
    task automatic test_fibonacci();
        send_pair(1836311903, 1134903170);
        send_pair(-1134903170, 1836311903);
    endtask

    task automatic test_random_pairs(input int idle_pct, input int stall_pct,
                                     input int count);
        word_t g;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            if ($urandom_range(3) == 0) begin
                // shared factor so the gcd is not trivially one
                g = word_t'($urandom_range(5000, 1));
                send_pair(random_sign(g * word_t'($urandom_range(400000))),
                          random_sign(g * word_t'($urandom_range(400000))));
            end else begin
                send_pair(random_operand(), random_operand());
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_zero_operands();
        test_extremes();
        test_fibonacci();
        test_random_pairs(0, 0, 92);
        test_random_pairs(77, 0, 92);
        test_random_pairs(0, 77, 92);
        test_random_pairs(15, 15, 92);

        s_tvalid <= 1'b0;
        while (pending_bezout.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d operand pairs: zeros, extremes, fibonacci chains, random pairs",
                 sent_count);
        $display("under four idle and stall mixes; %0d results checked, %0d mismatches",
                 checked_count, err_count);
        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
